### hdl/lad_pkg.sv
`timescale 1ns / 1ps

package lad_pkg;

  localparam int CAP_W    = 5;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;
  localparam int DATA_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_REFUSED   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic step;
  } lad_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_result;
    logic dump_walk;
    logic last;
  } lad_stat_t;

endpackage

### hdl/lad_ctrl.sv
`timescale 1ns / 1ps

module lad_ctrl import lad_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  lad_stat_t stat_i,
  output lad_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RESULT = 2'd1;
  localparam logic [1:0] S_DUMP   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       take;
  logic       in_ready;

  assign out_valid_o = (state_q != S_IDLE);
  assign take        = out_valid_o && !out_stall_i;

  // A new item may enter when the output register is free or is being emptied
  // this cycle, except in the middle of a dump walk.
  always_comb begin
    unique case (state_q)
      S_IDLE:   in_ready = 1'b1;
      S_RESULT: in_ready = take;
      S_DUMP:   in_ready = take && stat_i.last;
      default:  in_ready = 1'b0;
    endcase
  end

  assign in_stall_o = !in_ready;
  assign cmd_o.exec = in_valid_i && in_ready;
  assign cmd_o.step = (state_q == S_DUMP) && take && !stat_i.last;

  always_comb begin
    state_d = state_q;
    if (cmd_o.exec) begin
      if (!stat_i.has_result) begin
        state_d = S_IDLE;
      end else if (stat_i.dump_walk) begin
        state_d = S_DUMP;
      end else begin
        state_d = S_RESULT;
      end
    end else if (take) begin
      if (cmd_o.step) begin
        state_d = S_DUMP;
      end else begin
        state_d = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/lad_datapath.sv
`timescale 1ns / 1ps

module lad_datapath import lad_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  in_item_t         in_item_i,
  input  lad_cmd_t         cmd_i,
  output lad_stat_t        stat_o,
  output out_item_t        out_item_o
);

  localparam int IdxW = $clog2(DEPTH);
  localparam int CmpW = (IdxW + 1 > CAP_W) ? IdxW + 1 : CAP_W;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [CAP_W-1:0]    cap_q;
  logic [IdxW-1:0]     front_q, front_d;
  logic [IdxW-1:0]     rear_q, rear_d;
  logic [IdxW-1:0]     walk_q, walk_d;
  logic                empty_q, empty_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                last_q, last_d;
  logic                use_rd_q, use_rd_d;
  logic [DATA_W-1:0]   rd_q;

  logic              we, re;
  logic [IdxW-1:0]   waddr, raddr;
  logic [CmpW-1:0]   cap_ext, cap_eff;
  logic              overflow;
  logic [IdxW-1:0]   rear_inc, front_inc, front_dec, rear_dec, walk_inc;

  assign rear_inc  = rear_q + 1'b1;
  assign rear_dec  = rear_q - 1'b1;
  assign front_inc = front_q + 1'b1;
  assign front_dec = front_q - 1'b1;
  assign walk_inc  = walk_q + 1'b1;

  // The usable capacity is the register clamped to 1..DEPTH.
  always_comb begin
    cap_ext = CmpW'(cap_q);
    if (cap_ext == '0) begin
      cap_eff = CmpW'(1);
    end else if (cap_ext > CmpW'(DEPTH)) begin
      cap_eff = CmpW'(DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign overflow = (CmpW'(rear_q) + CmpW'(1)) >= cap_eff;

  always_comb begin
    front_d  = front_q;
    rear_d   = rear_q;
    empty_d  = empty_q;
    walk_d   = walk_q;
    status_d = status_q;
    last_d   = last_q;
    use_rd_d = use_rd_q;
    we       = 1'b0;
    waddr    = front_q;
    re       = 1'b0;
    raddr    = front_q;
    if (cmd_i.step) begin
      walk_d = walk_inc;
      re     = 1'b1;
      raddr  = walk_inc;
      last_d = (walk_inc == rear_q);
    end else if (cmd_i.exec) begin
      status_d = STATUS_OK;
      last_d   = 1'b1;
      use_rd_d = 1'b0;
      unique case (in_item_i.kind)
        KIND_PUSH_REAR: begin
          if (empty_q) begin
            front_d = '0;
            rear_d  = '0;
            empty_d = 1'b0;
            we      = 1'b1;
            waddr   = '0;
          end else if (overflow) begin
            status_d = STATUS_OVERFLOW;
          end else begin
            rear_d = rear_inc;
            we     = 1'b1;
            waddr  = rear_inc;
          end
        end
        KIND_POP_FRONT: begin
          if (empty_q) begin
            status_d = STATUS_UNDERFLOW;
          end else begin
            re       = 1'b1;
            raddr    = front_q;
            use_rd_d = 1'b1;
            if (front_q >= rear_q) begin
              front_d = '0;
              rear_d  = '0;
              empty_d = 1'b1;
            end else begin
              front_d = front_inc;
            end
          end
        end
        KIND_PUSH_FRONT: begin
          if (empty_q || front_q == '0) begin
            status_d = STATUS_REFUSED;
          end else begin
            front_d = front_dec;
            we      = 1'b1;
            waddr   = front_dec;
          end
        end
        KIND_POP_REAR: begin
          if (empty_q) begin
            status_d = STATUS_UNDERFLOW;
          end else begin
            re       = 1'b1;
            raddr    = rear_q;
            use_rd_d = 1'b1;
            if (front_q >= rear_q) begin
              front_d = '0;
              rear_d  = '0;
              empty_d = 1'b1;
            end else begin
              rear_d = rear_dec;
            end
          end
        end
        KIND_DUMP: begin
          if (empty_q) begin
            status_d = STATUS_EMPTY;
          end else begin
            re       = 1'b1;
            raddr    = front_q;
            use_rd_d = 1'b1;
            walk_d   = front_q;
            last_d   = (front_q == rear_q);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stat_o.has_result = (in_item_i.kind <= KIND_DUMP);
  assign stat_o.dump_walk  = (in_item_i.kind == KIND_DUMP) && !empty_q;
  assign stat_o.last       = last_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= in_item_i.value;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      front_q <= '0;
      rear_q  <= '0;
      empty_q <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      front_q <= front_d;
      rear_q  <= rear_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q   <= walk_d;
    status_q <= status_d;
    last_q   <= last_d;
    use_rd_q <= use_rd_d;
  end

  assign out_item_o.status = status_q;
  assign out_item_o.data   = use_rd_q ? rd_q : '0;
  assign out_item_o.last   = last_q;

endmodule

### hdl/linear_array_deque.sv
`timescale 1ns / 1ps
// Push and pop results appear in the cycle after the item is accepted.
// One item per cycle is taken while the output is not stalled and no dump is being walked out.
// A dump gives one element per cycle from the store's read port while the output is not stalled,
// and holds off new items until its last element is taken.
// Reset clears the front and rear indices, sets the empty flag and the capacity to 16; the store is not cleared.

module linear_array_deque import lad_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o
);

  lad_cmd_t  cmd;
  lad_stat_t stat;

  lad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lad_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_item_o  (out_item_o)
  );

endmodule

### hdl/lad_checker.sv
`timescale 1ns / 1ps

module lad_checker import lad_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // A held result must keep new items out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("item accepted while a result is stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Only a dump walk gives results without the last mark, and those are all ok.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != STATUS_OK |-> out_item_o.last)
    else $error("error result without last mark");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (in_item_i.kind == KIND_PUSH_REAR || in_item_i.kind == KIND_PUSH_FRONT)
    |=> out_valid_o && out_item_o.last && out_item_o.data == '0)
    else $error("push result missing or carries data");

endmodule

bind linear_array_deque lad_checker u_lad_checker (.*);

### test/deque_checker.sv
`timescale 1ns / 1ps

module deque_checker import lad_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  in_item_t         in_item_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  out_item_t        out_item_i,
  output int               mismatch_cnt_o,
  output int               awaited_cnt_o
);

  localparam int IdxW = $clog2(DEPTH);

  // Shadow copy of the deque contents and its bookkeeping.
  logic [DATA_W-1:0] slots [DEPTH];
  int unsigned       head;
  int unsigned       tail;
  logic              empty;
  logic [CAP_W-1:0]  capacity;
  out_item_t         awaited_results [$];
  out_item_t         want;

  function automatic int unsigned usable_capacity();
    if (capacity < 1) return 1;
    if (capacity > DEPTH) return 32'(DEPTH);
    return 32'(capacity);
  endfunction

  function automatic out_item_t make_result(input logic [STATUS_W-1:0] status,
                                            input logic [DATA_W-1:0]   data,
                                            input logic                last);
    out_item_t r;
    r.status = status;
    r.data   = data;
    r.last   = last;
    return r;
  endfunction

  task automatic apply_operation(input in_item_t op);
    logic [DATA_W-1:0] taken;
    int unsigned       i;
    case (op.kind)
      KIND_PUSH_REAR: begin
        if (empty) begin
          head     = 0;
          tail     = 0;
          slots[0] = op.value;
          empty    = 1'b0;
          awaited_results.push_back(make_result(STATUS_OK, '0, 1'b1));
        end else if (tail >= usable_capacity() - 1 || tail + 1 >= DEPTH) begin
          awaited_results.push_back(make_result(STATUS_OVERFLOW, '0, 1'b1));
        end else begin
          tail                = tail + 1;
          slots[IdxW'(tail)] = op.value;
          awaited_results.push_back(make_result(STATUS_OK, '0, 1'b1));
        end
      end
      KIND_POP_FRONT, KIND_POP_REAR: begin
        if (empty) begin
          awaited_results.push_back(make_result(STATUS_UNDERFLOW, '0, 1'b1));
        end else begin
          taken = (op.kind == KIND_POP_FRONT) ? slots[IdxW'(head)] : slots[IdxW'(tail)];
          // Taking the only element returns the deque to its reset shape.
          if (head >= tail) begin
            head  = 0;
            tail  = 0;
            empty = 1'b1;
          end else if (op.kind == KIND_POP_FRONT) begin
            head = head + 1;
          end else begin
            tail = tail - 1;
          end
          awaited_results.push_back(make_result(STATUS_OK, taken, 1'b1));
        end
      end
      KIND_PUSH_FRONT: begin
        if (empty || head == 0) begin
          awaited_results.push_back(make_result(STATUS_REFUSED, '0, 1'b1));
        end else begin
          head                = head - 1;
          slots[IdxW'(head)] = op.value;
          awaited_results.push_back(make_result(STATUS_OK, '0, 1'b1));
        end
      end
      KIND_DUMP: begin
        if (empty) begin
          awaited_results.push_back(make_result(STATUS_EMPTY, '0, 1'b1));
        end else begin
          for (i = head; i <= tail; i++) begin
            awaited_results.push_back(make_result(STATUS_OK, slots[IdxW'(i)], i == tail));
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_field(input string name, input logic [DATA_W-1:0] exp_v,
                              input logic [DATA_W-1:0] got_v);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    mismatch_cnt_o = mismatch_cnt_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head           = 0;
      tail           = 0;
      empty          = 1'b1;
      capacity       = CAP_RESET;
      mismatch_cnt_o = 0;
      awaited_results.delete();
      awaited_cnt_o  = 0;
    end else begin
      if (cfg_we_i) begin
        capacity = cfg_wdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, got %0h",
                   $time, out_item_i);
          mismatch_cnt_o = mismatch_cnt_o + 1;
        end else begin
          want = awaited_results.pop_front();
          if (out_item_i.status !== want.status)
            report_field("status", DATA_W'(want.status), DATA_W'(out_item_i.status));
          if (out_item_i.data !== want.data)
            report_field("data", want.data, out_item_i.data);
          if (out_item_i.last !== want.last)
            report_field("last", DATA_W'(want.last), DATA_W'(out_item_i.last));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_operation(in_item_i);
      end
      awaited_cnt_o = awaited_results.size();
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lad_pkg::*;

  localparam int DEPTH   = 16;
  localparam int PHASES  = 12;
  localparam int PER_PHASE = 35;
  localparam int MAX_GAP = 6;
  localparam int SETTLE  = 8;
  localparam int LIMIT   = 400000;

  // First of the kind codes that the block ignores.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd5;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  in_item_t         in_item_i;
  logic             out_valid_o;
  logic             out_stall_i;
  out_item_t        out_item_o;

  int          mismatches;
  int          outstanding;
  int unsigned cycles = 0;
  bit          calm   = 1'b0;

  // Operation mix per phase flavor: cumulative percentages for push rear,
  // push front, pop front, pop rear and dump; the rest are ignored kinds.
  int mix [3][5] = '{'{50, 65, 75, 82, 95},
                     '{20, 30, 60, 85, 95},
                     '{35, 55, 70, 85, 96}};

  logic [CAP_W-1:0] capacities [PHASES] = '{5'd1, 5'd0, 5'd2, 5'd31, 5'd16, 5'd4,
                                            5'd17, 5'd8, 5'd3, 5'd15, 5'd6, 5'd16};

  linear_array_deque #(.DEPTH(DEPTH)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  deque_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .in_item_i      (in_item_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_item_i     (out_item_o),
    .mismatch_cnt_o (mismatches),
    .awaited_cnt_o  (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [KIND_W-1:0] draw_kind(input int flavor);
    int         r;
    logic [1:0] f;
    f = 2'(flavor);
    r = $urandom_range(0, 99);
    if (r < mix[f][0]) return KIND_PUSH_REAR;
    if (r < mix[f][1]) return KIND_PUSH_FRONT;
    if (r < mix[f][2]) return KIND_POP_FRONT;
    if (r < mix[f][3]) return KIND_POP_REAR;
    if (r < mix[f][4]) return KIND_DUMP;
    return KIND_UNUSED + KIND_W'($urandom_range(0, 2));
  endfunction

  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value);
    in_item_t item;
    int       gap;
    item.kind  = kind;
    item.value = value;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drops valid and waits until every predicted result has been taken, then
  // waits on for items that give no result.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : receiver
    int hold;
    out_stall_i <= 1'b1;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin : stimulus
    int phase;
    int flavor;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every kind but push rear on an empty deque, then the ignored kinds.
    send_op(KIND_DUMP, $urandom());
    send_op(KIND_POP_FRONT, $urandom());
    send_op(KIND_POP_REAR, $urandom());
    send_op(KIND_PUSH_FRONT, $urandom());
    send_op(KIND_UNUSED, $urandom());
    send_op(KIND_UNUSED + 3'd1, $urandom());
    send_op(KIND_UNUSED + 3'd2, $urandom());
    // Extreme values, a refused front insert while front sits at slot zero.
    send_op(KIND_PUSH_REAR, 32'h7FFF_FFFF);
    send_op(KIND_PUSH_FRONT, 32'h0000_1234);
    send_op(KIND_PUSH_REAR, 32'h8000_0000);
    send_op(KIND_PUSH_REAR, 32'h0000_0000);
    send_op(KIND_PUSH_REAR, 32'hFFFF_FFFF);
    send_op(KIND_DUMP, $urandom());
    send_op(KIND_POP_FRONT, $urandom());
    send_op(KIND_PUSH_FRONT, 32'h5555_5555);
    send_op(KIND_POP_REAR, $urandom());
    send_op(KIND_POP_FRONT, $urandom());
    send_op(KIND_POP_REAR, $urandom());
    // Popping the last element from the rear empties the deque.
    send_op(KIND_POP_REAR, $urandom());
    send_op(KIND_POP_FRONT, $urandom());
    send_op(KIND_PUSH_REAR, 32'hAAAA_AAAA);
    send_op(KIND_POP_FRONT, $urandom());
    send_op(KIND_DUMP, $urandom());

    // The deque keeps its contents across capacity changes, so a lowered
    // capacity with a fuller deque gets exercised along the way.
    for (phase = 0; phase < PHASES; phase++) begin
      calm   = ($urandom_range(0, 2) == 0);
      flavor = $urandom_range(0, 2);
      if (phase == PHASES - 2)
        set_capacity(CAP_W'($urandom_range(0, 31)));
      else
        set_capacity(capacities[4'(phase)]);
      repeat (PER_PHASE) send_op(draw_kind(flavor), $urandom());
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
hdl/lad_pkg.sv
hdl/lad_ctrl.sv
hdl/lad_datapath.sv
hdl/linear_array_deque.sv
hdl/lad_checker.sv
test/deque_checker.sv
test/tb_top.sv
